// ===== src/kntas_pkg.sv =====
// Shared types and constants for the two-anchor nearest point selector.
`timescale 1ns / 1ps
`default_nettype none
package kntas_pkg;
    localparam int COORD_BITS = 16;
    localparam int MAX_KEEP = 16;
    localparam int DIST_BITS = COORD_BITS + 1;
    localparam int SUM_BITS = COORD_BITS + 2;
    localparam int IDX_BITS = $clog2(MAX_KEEP);
    localparam int FILL_BITS = $clog2(MAX_KEEP + 1);
    localparam int CNT_BITS = 5;
    localparam int SQ_BITS = 2 * (COORD_BITS + 1) + 2;
    localparam int ROOT_BITS = SQ_BITS / 2;
    localparam int RANK_BITS = 4;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [DIST_BITS-1:0] dist_t;
    typedef logic [SUM_BITS-1:0] sum_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X = 3'd3,
        CFG_END_Y = 3'd4,
        CFG_END_Z = 3'd5,
        CFG_SELECT = 3'd6,
        CFG_SPARE = 3'd7
    } cfg_idx_t;

    // Classified item handed from the distance front to the store back.
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        dist_t ds;
        dist_t de;
        logic last;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SQ = 2'd1,
        ST_ROOT = 2'd2,
        ST_DONE = 2'd3
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_INSERT = 2'd1,
        BK_EMIT = 2'd2
    } back_state_t;
endpackage
`default_nettype wire

// ===== src/kntas_front.sv =====
// Front end: squared distances and bit-serial integer roots for one point.
`timescale 1ns / 1ps
`default_nettype none
module kntas_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire kntas_pkg::coord_t point_x,
    input  wire kntas_pkg::coord_t point_y,
    input  wire kntas_pkg::coord_t point_z,
    input  wire logic last_point,
    input  wire kntas_pkg::coord_t start_x,
    input  wire kntas_pkg::coord_t start_y,
    input  wire kntas_pkg::coord_t start_z,
    input  wire kntas_pkg::coord_t end_x,
    input  wire kntas_pkg::coord_t end_y,
    input  wire kntas_pkg::coord_t end_z,
    output logic item_valid,
    input  wire logic item_ready,
    output kntas_pkg::item_t item
);
    import kntas_pkg::*;

    localparam int STEP_BITS = $clog2(ROOT_BITS + 1);
    localparam int AXIS_BITS = 2;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;

    front_state_t state_reg, state_next;
    coord_t px_reg, py_reg, pz_reg;
    logic last_reg;
    logic [AXIS_BITS-1:0] axis_reg;
    logic [SQ_BITS-1:0] sqs_reg, sqe_reg;
    logic [SQ_BITS-1:0] rems_reg, reme_reg;
    logic [ROOT_BITS-1:0] roots_reg, roote_reg;
    logic [STEP_BITS-1:0] step_reg;

    logic signed [DIFF_BITS-1:0] dfs, dfe;
    logic [PROD_BITS-1:0] prs, pre;
    coord_t pa, sa, ea;
    logic [SQ_BITS-1:0] rs_sh, re_sh;
    logic [ROOT_BITS+1:0] trys, trye;

    // Pick one axis per cycle, one multiplier per anchor.
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                pa = px_reg; sa = start_x; ea = end_x;
            end
            2'd1:
            begin
                pa = py_reg; sa = start_y; ea = end_y;
            end
            default:
            begin
                pa = pz_reg; sa = start_z; ea = end_z;
            end
        endcase
        dfs = DIFF_BITS'(pa) - DIFF_BITS'(sa);
        dfe = DIFF_BITS'(pa) - DIFF_BITS'(ea);
        prs = PROD_BITS'(dfs) * PROD_BITS'(dfs);
        pre = PROD_BITS'(dfe) * PROD_BITS'(dfe);
    end

    // One restoring root step: two radicand bits per cycle.
    always_comb
    begin
        rs_sh = {rems_reg[SQ_BITS-3:0], sqs_reg[SQ_BITS-1:SQ_BITS-2]};
        re_sh = {reme_reg[SQ_BITS-3:0], sqe_reg[SQ_BITS-1:SQ_BITS-2]};
        trys = {roots_reg, 2'b01};
        trye = {roote_reg, 2'b01};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (push) state_next = ST_SQ;
            ST_SQ: if (axis_reg == 2'd2) state_next = ST_ROOT;
            ST_ROOT: if (step_reg == STEP_BITS'(ROOT_BITS - 1)) state_next = ST_DONE;
            ST_DONE: if (item_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        full = (state_reg != ST_IDLE);
        item_valid = (state_reg == ST_DONE);
        item.x = px_reg;
        item.y = py_reg;
        item.z = pz_reg;
        item.ds = roots_reg[DIST_BITS-1:0];
        item.de = roote_reg[DIST_BITS-1:0];
        item.last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath: capture, accumulate squares, then iterate roots.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                px_reg <= point_x;
                py_reg <= point_y;
                pz_reg <= point_z;
                last_reg <= last_point;
                axis_reg <= '0;
                sqs_reg <= '0;
                sqe_reg <= '0;
            end
            ST_SQ:
            begin
                sqs_reg <= sqs_reg + SQ_BITS'(prs);
                sqe_reg <= sqe_reg + SQ_BITS'(pre);
                axis_reg <= axis_reg + 2'd1;
                rems_reg <= '0;
                reme_reg <= '0;
                roots_reg <= '0;
                roote_reg <= '0;
                step_reg <= '0;
            end
            ST_ROOT:
            begin
                sqs_reg <= sqs_reg << 2;
                sqe_reg <= sqe_reg << 2;
                step_reg <= step_reg + 1'b1;
                if (rs_sh >= SQ_BITS'(trys))
                begin
                    rems_reg <= rs_sh - SQ_BITS'(trys);
                    roots_reg <= {roots_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rems_reg <= rs_sh;
                    roots_reg <= {roots_reg[ROOT_BITS-2:0], 1'b0};
                end
                if (re_sh >= SQ_BITS'(trye))
                begin
                    reme_reg <= re_sh - SQ_BITS'(trye);
                    roote_reg <= {roote_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    reme_reg <= re_sh;
                    roote_reg <= {roote_reg[ROOT_BITS-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    a_done_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && step_reg == STEP_BITS'(ROOT_BITS - 1)) |=>
        state_reg == ST_DONE)
        else $error("root did not finish");
    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !item_ready) |=> state_reg == ST_DONE && $stable(item))
        else $error("item changed while stalled");
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && push) |=> full)
        else $error("accepted without going busy");
endmodule
`default_nettype wire

// ===== src/kntas_queue.sv =====
// Two-entry queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module kntas_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire kntas_pkg::item_t in_item,
    output logic out_valid,
    input  wire logic out_ready,
    output kntas_pkg::item_t out_item
);
    import kntas_pkg::*;

    item_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    always_comb
    begin
        in_ready = (cnt_reg != 2'd2);
        out_valid = (cnt_reg != 2'd0);
        wr = in_valid && in_ready;
        rd = out_valid && out_ready;
        out_item = mem_reg[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= in_item;
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers disagree with count");
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not grow");
endmodule
`default_nettype wire

// ===== src/kntas_back.sv =====
// Back end: sorted insertion chain and result emission.
`timescale 1ns / 1ps
`default_nettype none
module kntas_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic item_ready,
    input  wire kntas_pkg::item_t item,
    input  wire logic [kntas_pkg::CNT_BITS-1:0] select_count,
    output logic empty,
    input  wire logic pop,
    output kntas_pkg::coord_t near_x,
    output kntas_pkg::coord_t near_y,
    output kntas_pkg::coord_t near_z,
    output kntas_pkg::dist_t dist_to_start,
    output kntas_pkg::dist_t dist_to_end,
    output kntas_pkg::sum_t dist_sum,
    output logic [kntas_pkg::RANK_BITS-1:0] rank,
    output logic last_result
);
    import kntas_pkg::*;

    back_state_t state_reg, state_next;
    item_t ent_reg [MAX_KEEP];
    sum_t key_reg [MAX_KEEP];
    logic [FILL_BITS-1:0] fill_reg;
    logic [FILL_BITS-1:0] emit_reg;
    logic [FILL_BITS-1:0] cnt, fill_cl, fill_new;
    sum_t key;
    logic [MAX_KEEP-1:0] gt;
    logic fits;

    // Effective count: zero acts as one, clamp to store depth.
    always_comb
    begin
        if (select_count == '0)
            cnt = FILL_BITS'(1);
        else if (32'(select_count) > MAX_KEEP)
            cnt = FILL_BITS'(MAX_KEEP);
        else
            cnt = FILL_BITS'(select_count);
        fill_cl = (fill_reg > cnt) ? cnt : fill_reg;
        key = SUM_BITS'(item.ds) + SUM_BITS'(item.de);
        for (int i = 0; i < MAX_KEEP; i++)
            gt[i] = (FILL_BITS'(i) >= fill_cl) || (key_reg[i] > key);
        fits = 1'b0;
        for (int i = 0; i < MAX_KEEP; i++)
            if (FILL_BITS'(i) < cnt && gt[i]) fits = 1'b1;
        fill_new = (fill_cl < cnt) ? fill_cl + 1'b1 : fill_cl;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (item_valid) state_next = BK_INSERT;
            BK_INSERT: state_next = item.last ? BK_EMIT : BK_IDLE;
            BK_EMIT: if (pop && emit_reg + 1'b1 == fill_reg) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == BK_INSERT);
        empty = (state_reg != BK_EMIT);
        near_x = ent_reg[emit_reg[IDX_BITS-1:0]].x;
        near_y = ent_reg[emit_reg[IDX_BITS-1:0]].y;
        near_z = ent_reg[emit_reg[IDX_BITS-1:0]].z;
        dist_to_start = ent_reg[emit_reg[IDX_BITS-1:0]].ds;
        dist_to_end = ent_reg[emit_reg[IDX_BITS-1:0]].de;
        dist_sum = key_reg[emit_reg[IDX_BITS-1:0]];
        rank = RANK_BITS'(emit_reg);
        last_result = (emit_reg + 1'b1 == fill_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            fill_reg <= '0;
            emit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_INSERT)
            begin
                fill_reg <= fits ? fill_new : fill_cl;
                emit_reg <= '0;
            end
            else if (state_reg == BK_EMIT && pop)
            begin
                emit_reg <= emit_reg + 1'b1;
                if (emit_reg + 1'b1 == fill_reg) fill_reg <= '0;
            end
        end
    end

    // Shift every cell above the insert point up by one; drop the tail.
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_INSERT && fits)
        begin
            for (int i = 0; i < MAX_KEEP; i++)
            begin
                if (gt[i])
                begin
                    if (i == 0 || !gt[(i == 0) ? 0 : i - 1])
                    begin
                        ent_reg[i] <= item;
                        key_reg[i] <= key;
                    end
                    else
                    begin
                        ent_reg[i] <= ent_reg[(i == 0) ? 0 : i - 1];
                        key_reg[i] <= key_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
    end

    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EMIT |-> fill_reg != '0 && emit_reg < fill_reg)
        else $error("emitting past fill");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_KEEP)
        else $error("fill beyond depth");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT && pop && last_result) |=> fill_reg == '0)
        else $error("store not cleared after set");
endmodule
`default_nettype wire

// ===== src/k_nearest_two_anchor_select.sv =====
// Top level of the two-anchor nearest point selector.
//  channel  | handshake            | payload
//  input    | push / full          | point_x, point_y, point_z, last_point
//  result   | empty / pop          | near_*, dist_*, rank, last_result
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
// A point is squared one axis at a time and then takes 18 root steps in the front;
// the bit-serial root unit sets the rate, and the front takes no new point until
// the last one has been handed on.
// The back takes each item through BK_IDLE and then BK_INSERT, where it inserts it,
// before it takes the next; emission gives one result per pop beat.
// A two-entry queue lets the front keep working while results are drained.
// Reset restores the anchor registers and empties the store at once.
`timescale 1ns / 1ps
`default_nettype none
module k_nearest_two_anchor_select (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire kntas_pkg::coord_t point_x,
    input  wire kntas_pkg::coord_t point_y,
    input  wire kntas_pkg::coord_t point_z,
    input  wire logic last_point,
    output logic empty,
    input  wire logic pop,
    output kntas_pkg::coord_t near_x,
    output kntas_pkg::coord_t near_y,
    output kntas_pkg::coord_t near_z,
    output kntas_pkg::dist_t dist_to_start,
    output kntas_pkg::dist_t dist_to_end,
    output kntas_pkg::sum_t dist_sum,
    output logic [kntas_pkg::RANK_BITS-1:0] rank,
    output logic last_result,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [kntas_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [kntas_pkg::COORD_BITS-1:0] cfg_data
);
    import kntas_pkg::*;

    coord_t sx_reg, sy_reg, sz_reg, ex_reg, ey_reg, ez_reg;
    logic [CNT_BITS-1:0] sel_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    item_t f_item, b_item;

    assign cfg_ready = 1'b1;

    // Register file writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= COORD_BITS'(3850);
            sy_reg <= '0;
            sz_reg <= COORD_BITS'(1065);
            ex_reg <= COORD_BITS'(3850);
            ey_reg <= COORD_BITS'(3031);
            ez_reg <= COORD_BITS'(1065);
            sel_reg <= CNT_BITS'(12);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_X: sx_reg <= cfg_data;
                CFG_START_Y: sy_reg <= cfg_data;
                CFG_START_Z: sz_reg <= cfg_data;
                CFG_END_X: ex_reg <= cfg_data;
                CFG_END_Y: ey_reg <= cfg_data;
                CFG_END_Z: ez_reg <= cfg_data;
                CFG_SELECT: sel_reg <= cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    kntas_front u_front (
        .clk, .rst_n, .push, .full, .point_x, .point_y, .point_z, .last_point,
        .start_x(sx_reg), .start_y(sy_reg), .start_z(sz_reg),
        .end_x(ex_reg), .end_y(ey_reg), .end_z(ez_reg),
        .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
    );

    kntas_queue u_queue (
        .clk, .rst_n, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
    );

    kntas_back u_back (
        .clk, .rst_n, .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
        .select_count(sel_reg), .empty, .pop, .near_x, .near_y, .near_z,
        .dist_to_start, .dist_to_end, .dist_sum, .rank, .last_result
    );
endmodule
`default_nettype wire

// ===== sim/tb_k_nearest_two_anchor_select.sv =====
// Self-checking testbench for the two-anchor nearest point selector.
`timescale 1ns / 1ps
`default_nettype none
module tb_k_nearest_two_anchor_select;
    import kntas_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        dist_t ds;
        dist_t de;
        sum_t sum;
        logic [RANK_BITS-1:0] rank;
        logic last;
    } near_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    coord_t point_x, point_y, point_z;
    logic last_point;
    logic empty;
    logic pop;
    coord_t near_x, near_y, near_z;
    dist_t dist_to_start, dist_to_end;
    sum_t dist_sum;
    logic [RANK_BITS-1:0] rank;
    logic last_result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0] cfg_data;

    // Predictor state
    coord_t anchor_s [3];
    coord_t anchor_e [3];
    logic [CNT_BITS-1:0] keep_cfg;
    near_t kept [MAX_KEEP];
    int kept_n;
    near_t nearest_q [$];

    int fail_cnt;
    int idle_cycles;
    bit hold_off;
    bit gaps_on;

    k_nearest_two_anchor_select u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .last_point(last_point), .empty(empty), .pop(pop),
        .near_x(near_x), .near_y(near_y), .near_z(near_z),
        .dist_to_start(dist_to_start), .dist_to_end(dist_to_end),
        .dist_sum(dist_sum), .rank(rank), .last_result(last_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic dist_t anchor_dist(coord_t px, coord_t py, coord_t pz,
                                          coord_t a [3]);
        longint dx, dy, dz;
        dx = longint'(px) - longint'(a[0]);
        dy = longint'(py) - longint'(a[1]);
        dz = longint'(pz) - longint'(a[2]);
        return dist_t'(root_floor(dx * dx + dy * dy + dz * dz));
    endfunction

    // Update the sorted store with one point; emit on the last one
    task automatic predict_point(coord_t px, coord_t py, coord_t pz, logic lst);
        near_t e;
        int cnt, pos, top;
        e.x = px;
        e.y = py;
        e.z = pz;
        e.ds = anchor_dist(px, py, pz, anchor_s);
        e.de = anchor_dist(px, py, pz, anchor_e);
        e.sum = sum_t'(e.ds) + sum_t'(e.de);
        cnt = (keep_cfg == 0) ? 1 : (keep_cfg > MAX_KEEP) ? MAX_KEEP : int'(keep_cfg);
        if (kept_n > cnt)
            kept_n = cnt;
        pos = 0;
        while (pos < kept_n && kept[pos].sum <= e.sum)
            pos++;
        if (pos < cnt)
        begin
            top = (kept_n < cnt) ? kept_n : cnt - 1;
            for (int i = top; i > pos; i--)
                kept[i] = kept[i - 1];
            kept[pos] = e;
            if (kept_n < cnt)
                kept_n++;
        end
        if (lst)
        begin
            for (int i = 0; i < kept_n; i++)
            begin
                e = kept[i];
                e.rank = i[RANK_BITS-1:0];
                e.last = (i + 1 == kept_n);
                nearest_q = {nearest_q, e};
            end
            kept_n = 0;
        end
    endtask

    // Send one beat on the input side, with a random gap first when gaps are on
    task automatic send_point(coord_t px, coord_t py, coord_t pz, logic lst);
        int gap;
        gap = 0;
        if (gaps_on)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        last_point <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_point(px, py, pz, lst);
        // leave push high so the next beat can follow at once
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (nearest_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [COORD_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_START_X: anchor_s[0] = coord_t'(val);
            CFG_START_Y: anchor_s[1] = coord_t'(val);
            CFG_START_Z: anchor_s[2] = coord_t'(val);
            CFG_END_X: anchor_e[0] = coord_t'(val);
            CFG_END_Y: anchor_e[1] = coord_t'(val);
            CFG_END_Z: anchor_e[2] = coord_t'(val);
            CFG_SELECT: keep_cfg = val[CNT_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(16'h7fff);
            1: return coord_t'(16'h8000);
            2: return coord_t'($urandom_range(0, 400)) - coord_t'(200);
            default: return coord_t'($urandom());
        endcase
    endfunction

    task automatic test_directed_extremes();
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send_point(16'sh0f0a, 16'sh0000, 16'sh0429, 1'b0);
        send_point(16'sh0f0a, 16'sh0bd7, 16'sh0429, 1'b0);
        // equal keys: earlier point stays ahead
        send_point(16'sh0010, 16'sh0000, 16'sh0000, 1'b0);
        send_point(16'sh0010, 16'sh0000, 16'sh0000, 1'b0);
        send_point(16'shffff, 16'sh5555, 16'shaaaa, 1'b1);
        // lone point marked last
        send_point(16'sh1234, 16'shedcb, 16'sh0001, 1'b1);
        wait_drained();
    endtask

    task automatic test_full_store_discard();
        write_reg(CFG_SELECT, 16'd2);
        send_point(16'sh0f0a, 16'sh0000, 16'sh0429, 1'b0);
        send_point(16'sh0f0a, 16'sh0100, 16'sh0429, 1'b0);
        send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh0f0a, 16'sh0bd7, 16'sh0429, 1'b1);
        wait_drained();
    endtask

    task automatic test_count_extremes();
        // zero acts as one, above sixteen clamps to sixteen
        write_reg(CFG_SELECT, 16'd0);
        for (int i = 0; i < 4; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 3);
        wait_drained();
        write_reg(CFG_SELECT, 16'd31);
        for (int i = 0; i < 20; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 19);
        wait_drained();
        write_reg(CFG_SPARE, 16'hffff);
    endtask

    task automatic test_anchor_extremes();
        write_reg(CFG_START_X, 16'h8000);
        write_reg(CFG_START_Y, 16'h8000);
        write_reg(CFG_START_Z, 16'h8000);
        write_reg(CFG_END_X, 16'h7fff);
        write_reg(CFG_END_Y, 16'h7fff);
        write_reg(CFG_END_Z, 16'h7fff);
        write_reg(CFG_SELECT, 16'd16);
        for (int i = 0; i < 6; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 5);
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while points keep coming
    task automatic test_backpressure();
        write_reg(CFG_SELECT, 16'd16);
        hold_off = 1'b1;
        fork
            begin
                int held;
                held = 0;
                while (held < 1500)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < 60; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), (i % 5) == 4);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int sent, len;
        sent = 0;
        while (sent < 300)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(CFG_START_X, 16'($urandom()));
                write_reg(CFG_START_Y, 16'($urandom()));
                write_reg(CFG_START_Z, 16'($urandom()));
                write_reg(CFG_END_X, 16'($urandom()));
                write_reg(CFG_END_Y, 16'($urandom()));
                write_reg(CFG_END_Z, 16'($urandom()));
                write_reg(CFG_SELECT, 16'($urandom_range(0, 31)));
            end
            gaps_on = ($urandom_range(0, 4) != 0);
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
            begin
                send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
                // lower the count mid-set now and then
                if (i == len / 2 && $urandom_range(0, 9) == 0)
                begin
                    wait_drained();
                    write_reg(CFG_SELECT, 16'($urandom_range(1, 4)));
                end
            end
            sent += len;
            wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    // Drive pop with random gaps; hold it low during the pressure stretch
    initial
    begin
        int gap;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                pop <= 1'b0;
            else if ($urandom_range(0, 1) == 0)
                pop <= 1'b1;
            else
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : 1;
                pop <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // Compare each popped beat with the oldest expectation
    always @(posedge clk)
    begin
        near_t e;
        if (rst_n && pop && !empty)
        begin
            if (nearest_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end
            else
            begin
                e = nearest_q.pop_front();
                if (near_x !== e.x) begin $error("near_x exp %0d got %0d", e.x, near_x); fail_cnt++; end
                if (near_y !== e.y) begin $error("near_y exp %0d got %0d", e.y, near_y); fail_cnt++; end
                if (near_z !== e.z) begin $error("near_z exp %0d got %0d", e.z, near_z); fail_cnt++; end
                if (dist_to_start !== e.ds)
                begin
                    $error("dist_to_start exp %0d got %0d", e.ds, dist_to_start);
                    fail_cnt++;
                end
                if (dist_to_end !== e.de)
                begin
                    $error("dist_to_end exp %0d got %0d", e.de, dist_to_end);
                    fail_cnt++;
                end
                if (dist_sum !== e.sum)
                begin
                    $error("dist_sum exp %0d got %0d", e.sum, dist_sum);
                    fail_cnt++;
                end
                if (rank !== e.rank) begin $error("rank exp %0d got %0d", e.rank, rank); fail_cnt++; end
                if (last_result !== e.last)
                begin
                    $error("last_result exp %0d got %0d", e.last, last_result);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        last_point = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_cnt = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        gaps_on = 1'b1;
        anchor_s[0] = 16'sd3850;
        anchor_s[1] = 16'sd0;
        anchor_s[2] = 16'sd1065;
        anchor_e[0] = 16'sd3850;
        anchor_e[1] = 16'sd3031;
        anchor_e[2] = 16'sd1065;
        keep_cfg = 5'd12;
        kept_n = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_full_store_discard();
        test_count_extremes();
        test_anchor_extremes();
        test_backpressure();
        test_random_sets();
        wait_drained();

        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/kntas_pkg.sv
src/kntas_front.sv
src/kntas_queue.sv
src/kntas_back.sv
src/k_nearest_two_anchor_select.sv
sim/tb_k_nearest_two_anchor_select.sv
